// File: rtl/ppfh_pkg.sv
// ----------------------------------------------------------------------------
// ppfh_pkg: shared types and helpers for the planar pose unit
// Item layouts, register indexes, pipeline latencies and saturation helpers.
// ----------------------------------------------------------------------------
package ppfh_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOCAL_X  = 3'd0,
    REG_FOCAL_Y  = 3'd1,
    REG_SKEW     = 3'd2,
    REG_CENTER_X = 3'd3,
    REG_CENTER_Y = 3'd4
  } cfg_reg_e;

  localparam logic [31:0] FOCAL_RESET = 32'd32768000;

  // Latency of the divider and the square root units, in enabled cycles.
  localparam int DIV_LAT  = 34;
  localparam int SQRT_LAT = 33;

  localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  localparam int SAT_W = 68;
  localparam logic signed [SAT_W-1:0] SAT_HI = 68'sd2147483647;
  localparam logic signed [SAT_W-1:0] SAT_LO = -68'sd2147483648;

  // One homography item.
  typedef struct packed {
    logic signed [31:0] h00;
    logic signed [31:0] h01;
    logic signed [31:0] h02;
    logic signed [31:0] h10;
    logic signed [31:0] h11;
    logic signed [31:0] h12;
    logic signed [31:0] h20;
    logic signed [31:0] h21;
    logic signed [31:0] h22;
  } in_item_t;

  // One pose row item.
  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [31:0] rot_col0;
    logic signed [31:0] rot_col1;
    logic signed [31:0] rot_col2;
    logic signed [31:0] translation;
    logic               last_row;
    logic               degenerate;
  } out_item_t;

  // Clamp a wide signed value to signed 32 bits.
  function automatic logic [31:0] sat32(input logic signed [SAT_W-1:0] v);
    logic [31:0] r;
    if (v > SAT_HI) r = Q_MAX;
    else if (v < SAT_LO) r = Q_MIN;
    else r = v[31:0];
    return r;
  endfunction

  // Magnitude of a signed 32-bit value as unsigned 32 bits.
  function automatic logic [31:0] abs32(input logic [31:0] v);
    logic [31:0] r;
    r = v[31] ? (~v + 32'd1) : v;
    return r;
  endfunction

endpackage

// File: rtl/ppfh_stream_if.sv
// ----------------------------------------------------------------------------
// ppfh_stream_if: valid/ready item channel
// Carries one payload item per handshake; the payload type is a parameter.
// ----------------------------------------------------------------------------
interface ppfh_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: rtl/planar_pose_from_homography_unit.sv
// ----------------------------------------------------------------------------
// planar_pose_from_homography_unit: camera pose from a planar homography
// Applies the inverse intrinsic matrix to each homography column, normalizes
// by the first column length and emits three pose rows per item.
//
//   channel  dir  payload                          per item
//   in_ch    in   h00..h22                         one homography
//   out_ch   out  row_index, rot_col0..2, trans.,  three rows, last_row on
//                 last_row, degenerate             the third
//   cfg      in   cfg_wr_en, cfg_index, cfg_data   one register write
//
// The path to the first row runs through two divider pipelines, the square
// root pipeline and a third divider bank.
// The output emits one row per cycle while out_ch is ready, and a new item is
// taken only as the last row of the previous one is handed off; in_ch.ready is
// high in every cycle the row buffer is empty or is handing off its last row.
// A stall on out_ch freezes the whole pipeline; nothing is lost or repeated.
// Reset (rst, synchronous) clears valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module planar_pose_from_homography_unit import ppfh_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  ppfh_stream_if.sink          in_ch,
  ppfh_stream_if.source        out_ch
);

  localparam logic [1:0] ROW_FIRST = 2'd0;
  localparam logic [1:0] ROW_LAST  = 2'd2;

  logic [31:0] focal_x, focal_y, skew_term, center_x, center_y;
  logic        adv;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x   <= FOCAL_RESET;
      focal_y   <= FOCAL_RESET;
      skew_term <= '0;
      center_x  <= '0;
      center_y  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FOCAL_X:  focal_x   <= cfg_data;
        REG_FOCAL_Y:  focal_y   <= cfg_data;
        REG_SKEW:     skew_term <= cfg_data;
        REG_CENTER_X: center_x  <= cfg_data;
        REG_CENTER_Y: center_y  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1: register the item as rows (a, b, c), indexed by column.
  logic            v1;
  logic [2:0][31:0] a1, b1, c1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= in_ch.valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1 <= {in_ch.data.h02, in_ch.data.h01, in_ch.data.h00};
      b1 <= {in_ch.data.h12, in_ch.data.h11, in_ch.data.h10};
      c1 <= {in_ch.data.h22, in_ch.data.h21, in_ch.data.h20};
    end
  end

  // Stage 2: principal point products with the third entry.
  logic             v2;
  logic [2:0][31:0] a2, b2, c2;
  logic [2:0][63:0] pcy2, pcx2;
  logic signed [32:0] cy_s, cx_s;
  logic signed [64:0] pcy_w [3];
  logic signed [64:0] pcx_w [3];

  always_comb begin
    cy_s = $signed({1'b0, center_y});
    cx_s = $signed({1'b0, center_x});
    for (int j = 0; j < 3; j++) begin
      pcy_w[j] = cy_s * $signed(c1[j]);
      pcx_w[j] = cx_s * $signed(c1[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a2 <= a1;
      b2 <= b1;
      c2 <= c1;
      for (int j = 0; j < 3; j++) begin
        pcy2[j] <= pcy_w[j][63:0];
        pcx2[j] <= pcx_w[j][63:0];
      end
    end
  end

  // Stage 3: second row numerator, and the scaled cx term for later.
  logic             v3;
  logic [2:0][31:0] a3, c3, nb3;
  logic [2:0][63:0] cxs3;
  logic signed [SAT_W-1:0] nb_w [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      nb_w[j] = $signed(b2[j]) - ($signed(pcy2[j]) >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a3 <= a2;
      c3 <= c2;
      for (int j = 0; j < 3; j++) begin
        nb3[j]  <= sat32(nb_w[j]);
        cxs3[j] <= 64'($signed(pcx2[j]) >>> FRAC_BITS);
      end
    end
  end

  // Divider bank one: x1 = nb / fy.
  logic [2:0][31:0] x1_d;
  logic             v_d1;
  logic [2:0][31:0] a_d1, c_d1;
  logic [2:0][63:0] cxs_d1;

  for (genvar j = 0; j < 3; j++) begin : g_div1
    ppfh_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk(clk), .en(adv), .num(nb3[j]), .den(focal_y), .quo(x1_d[j])
    );
  end

  ppfh_delay #(.WIDTH(384), .DEPTH(DIV_LAT)) u_dly1 (
    .clk(clk), .rst(rst), .en(adv),
    .in_valid(v3), .in_data({a3, cxs3, c3}),
    .out_valid(v_d1), .out_data({a_d1, cxs_d1, c_d1})
  );

  // Stage 4: skew product.
  logic             v4;
  logic [2:0][31:0] a4, c4, x1_4;
  logic [2:0][63:0] cxs4, ps4;
  logic signed [63:0] ps_w [3];

  always_comb begin
    for (int j = 0; j < 3; j++) ps_w[j] = $signed(skew_term) * $signed(x1_d[j]);
  end

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v_d1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a4   <= a_d1;
      c4   <= c_d1;
      cxs4 <= cxs_d1;
      x1_4 <= x1_d;
      for (int j = 0; j < 3; j++) ps4[j] <= ps_w[j];
    end
  end

  // Stage 5: first row numerator.
  logic             v5;
  logic [2:0][31:0] c5, x1_5, na5;
  logic signed [SAT_W-1:0] na_w [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      na_w[j] = $signed(a4[j]) - ($signed(ps4[j]) >>> FRAC_BITS) - $signed(cxs4[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (adv) v5 <= v4;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c5   <= c4;
      x1_5 <= x1_4;
      for (int j = 0; j < 3; j++) na5[j] <= sat32(na_w[j]);
    end
  end

  // Divider bank two: x0 = na / fx.
  logic [2:0][31:0] x0_d, x1_d2, c_d2;
  logic             v_d2;

  for (genvar j = 0; j < 3; j++) begin : g_div2
    ppfh_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk(clk), .en(adv), .num(na5[j]), .den(focal_x), .quo(x0_d[j])
    );
  end

  ppfh_delay #(.WIDTH(192), .DEPTH(DIV_LAT)) u_dly2 (
    .clk(clk), .rst(rst), .en(adv),
    .in_valid(v5), .in_data({x1_5, c5}),
    .out_valid(v_d2), .out_data({x1_d2, c_d2})
  );

  // Stage 6: squares of the first column entries.
  logic                  v6;
  logic [2:0][2:0][31:0] m6;
  logic [2:0][63:0]      sq6;
  logic [31:0]           mg [3];

  always_comb begin
    mg[0] = abs32(x0_d[0]);
    mg[1] = abs32(x1_d2[0]);
    mg[2] = abs32(c_d2[0]);
  end

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (adv) v6 <= v_d2;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        m6[j] <= {c_d2[j], x1_d2[j], x0_d[j]};
        sq6[j] <= mg[j] * mg[j];
      end
    end
  end

  // Stage 7: sum of squares.
  logic                  v7;
  logic [2:0][2:0][31:0] m7;
  logic [63:0]           sum7;

  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (adv) v7 <= v6;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m7   <= m6;
      sum7 <= sq6[0] + sq6[1] + sq6[2];
    end
  end

  // Column length.
  logic [31:0]           norm;
  logic                  v_d3;
  logic [2:0][2:0][31:0] m_d3;

  ppfh_isqrt u_sqrt (.clk(clk), .en(adv), .x(sum7), .root(norm));

  ppfh_delay #(.WIDTH(288), .DEPTH(SQRT_LAT)) u_dly3 (
    .clk(clk), .rst(rst), .en(adv),
    .in_valid(v7), .in_data(m7),
    .out_valid(v_d3), .out_data(m_d3)
  );

  // Divider bank three: every entry of the three columns over the length.
  logic [2:0][2:0][31:0] rr;
  logic                  v_d4;
  logic                  dg_d4;

  for (genvar j = 0; j < 3; j++) begin : g_col
    for (genvar i = 0; i < 3; i++) begin : g_ent
      ppfh_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk(clk), .en(adv), .num(m_d3[j][i]), .den(norm), .quo(rr[j][i])
      );
    end
  end

  ppfh_delay #(.WIDTH(1), .DEPTH(DIV_LAT)) u_dly4 (
    .clk(clk), .rst(rst), .en(adv),
    .in_valid(v_d3), .in_data(norm == '0),
    .out_valid(v_d4), .out_data(dg_d4)
  );

  // Stage 8: cross product partial products.
  logic             v8, dg8;
  logic [2:0][31:0] r0_8, r1_8, t8;
  logic [5:0][63:0] pr8;
  logic signed [63:0] pr_w [6];

  always_comb begin
    pr_w[0] = $signed(rr[0][1]) * $signed(rr[1][2]);
    pr_w[1] = $signed(rr[0][2]) * $signed(rr[1][1]);
    pr_w[2] = $signed(rr[0][2]) * $signed(rr[1][0]);
    pr_w[3] = $signed(rr[0][0]) * $signed(rr[1][2]);
    pr_w[4] = $signed(rr[0][0]) * $signed(rr[1][1]);
    pr_w[5] = $signed(rr[0][1]) * $signed(rr[1][0]);
  end

  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else if (adv) v8 <= v_d4;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dg8  <= dg_d4;
      r0_8 <= rr[0];
      r1_8 <= rr[1];
      t8   <= rr[2];
      for (int k = 0; k < 6; k++) pr8[k] <= pr_w[k];
    end
  end

  // Row buffer: holds one item's three rows and plays them out in order.
  logic        sv, dg;
  logic [1:0]  row;
  logic [31:0] rc0 [3];
  logic [31:0] rc1 [3];
  logic [31:0] rc2 [3];
  logic [31:0] tr  [3];
  logic signed [64:0] df [3];

  always_comb begin
    for (int k = 0; k < 3; k++) df[k] = $signed(pr8[2*k]) - $signed(pr8[2*k+1]);
  end

  assign adv = !sv || (out_ch.ready && (row == ROW_LAST));

  always_ff @(posedge clk) begin
    if (rst) begin
      sv  <= 1'b0;
      row <= ROW_FIRST;
    end else if (adv) begin
      sv  <= v8;
      row <= ROW_FIRST;
    end else if (out_ch.ready) begin
      row <= row + 2'd1;
    end
  end

  // Degenerate items give zero in every numeric field.
  always_ff @(posedge clk) begin
    if (adv) begin
      dg <= dg8;
      for (int k = 0; k < 3; k++) begin
        rc0[k] <= dg8 ? '0 : r0_8[k];
        rc1[k] <= dg8 ? '0 : r1_8[k];
        rc2[k] <= dg8 ? '0 : sat32(SAT_W'(df[k] >>> FRAC_BITS));
        tr[k]  <= dg8 ? '0 : t8[k];
      end
    end
  end

  assign in_ch.ready                = adv;
  assign out_ch.valid               = sv;
  assign out_ch.data.row_index      = row;
  assign out_ch.data.rot_col0       = rc0[row];
  assign out_ch.data.rot_col1       = rc1[row];
  assign out_ch.data.rot_col2       = rc2[row];
  assign out_ch.data.translation    = tr[row];
  assign out_ch.data.last_row       = (row == ROW_LAST);
  assign out_ch.data.degenerate     = dg;

  // Checks on the row buffer.
  a_row_step: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.ready && (row != ROW_LAST) |=>
      out_ch.valid && (row == $past(row) + 2'd1))
    else $error("row index did not step after a taken row");

  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !(out_ch.ready && out_ch.data.last_row) |-> !in_ch.ready)
    else $error("pipeline advanced while rows were still pending");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.data.degenerate |->
      (out_ch.data.rot_col0 == '0) && (out_ch.data.rot_col1 == '0) &&
      (out_ch.data.rot_col2 == '0) && (out_ch.data.translation == '0))
    else $error("degenerate row carries nonzero values");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (row == 2'd0) || (row == 2'd1) || (row == ROW_LAST))
    else $error("row index out of range");

endmodule

// File: rtl/ppfh_delay.sv
// ----------------------------------------------------------------------------
// ppfh_delay: enabled delay line with valid bits
// Carries side data and the valid bit alongside a pipelined arithmetic unit.
// ----------------------------------------------------------------------------
module ppfh_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  output logic [WIDTH-1:0] out_data
);

  logic             vl [DEPTH];
  logic [WIDTH-1:0] dl [DEPTH];

  // Valid bits are control state and are cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DEPTH; k++) vl[k] <= 1'b0;
    end else if (en) begin
      vl[0] <= in_valid;
      for (int k = 1; k < DEPTH; k++) vl[k] <= vl[k-1];
    end
  end

  // Payload taps shift with the same enable.
  always_ff @(posedge clk) begin
    if (en) begin
      dl[0] <= in_data;
      for (int k = 1; k < DEPTH; k++) dl[k] <= dl[k-1];
    end
  end

  assign out_valid = vl[DEPTH-1];
  assign out_data  = dl[DEPTH-1];

endmodule

// File: rtl/ppfh_div.sv
// ----------------------------------------------------------------------------
// ppfh_div: pipelined fixed-point divider
// Computes sat32((num * 2^FRAC_BITS) / den) truncated toward zero, one
// quotient bit per stage, with an entry stage, restoring stages and a saturating output stage.
// ----------------------------------------------------------------------------
module ppfh_div import ppfh_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic [31:0] quo
);

  localparam int QB = 32;

  logic [31:0] rm [QB+1];
  logic [31:0] qt [QB+1];
  logic [31:0] lo [QB+1];
  logic [31:0] dv [QB+1];
  logic        ng [QB+1];
  logic        ov [QB+1];
  logic        zr [QB+1];
  logic [32:0] trial [QB];
  logic        take [QB];
  logic [31:0] mag;

  assign mag = abs32(num);

  // Trial subtraction for each stage.
  always_comb begin
    for (int k = 0; k < QB; k++) begin
      trial[k] = {rm[k], lo[k][31]};
      take[k]  = trial[k] >= {1'b0, dv[k]};
    end
  end

  // Entry stage, restoring stages and the saturating output stage.
  always_ff @(posedge clk) begin
    if (en) begin
      // A quotient of 2^32 or more is flagged here, so 32 bits suffice.
      rm[0] <= mag >> (32 - FRAC_BITS);
      lo[0] <= mag << FRAC_BITS;
      qt[0] <= '0;
      dv[0] <= den;
      ng[0] <= num[31];
      zr[0] <= (num == '0);
      ov[0] <= {32'b0, mag} >= ({32'b0, den} << (32 - FRAC_BITS));
      for (int k = 0; k < QB; k++) begin
        rm[k+1] <= take[k] ? 32'(trial[k] - {1'b0, dv[k]}) : trial[k][31:0];
        qt[k+1] <= {qt[k][30:0], take[k]};
        lo[k+1] <= {lo[k][30:0], 1'b0};
        dv[k+1] <= dv[k];
        ng[k+1] <= ng[k];
        ov[k+1] <= ov[k];
        zr[k+1] <= zr[k];
      end
      if (zr[QB]) begin
        quo <= '0;
      end else if (!ng[QB]) begin
        quo <= (ov[QB] || qt[QB][31]) ? Q_MAX : qt[QB];
      end else begin
        quo <= (ov[QB] || (qt[QB] > Q_MIN)) ? Q_MIN : (~qt[QB] + 32'd1);
      end
    end
  end

endmodule

// File: rtl/ppfh_isqrt.sv
// ----------------------------------------------------------------------------
// ppfh_isqrt: pipelined integer square root
// Floor square root of a 64-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module ppfh_isqrt import ppfh_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] x,
  output logic [31:0] root
);

  localparam int NS = 32;

  logic [63:0] xr [NS];
  logic [63:0] rs [NS+1];
  logic [63:0] bt [NS];
  logic [63:0] sm [NS];
  logic        go [NS];

  // Digit test for each stage against its fixed bit weight.
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      bt[k] = 64'd1 << (62 - 2 * k);
      sm[k] = rs[k] + bt[k];
      go[k] = xr[k] >= sm[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xr[0] <= x;
      rs[0] <= '0;
      for (int k = 0; k < NS; k++) begin
        if (k < NS - 1) xr[k+1] <= go[k] ? (xr[k] - sm[k]) : xr[k];
        rs[k+1] <= go[k] ? ((rs[k] >> 1) + bt[k]) : (rs[k] >> 1);
      end
    end
  end

  assign root = rs[NS][31:0];

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the planar pose unit
// Drives homography items through a randomly idling source, checks each pose
// row against an in-bench fixed-point predictor, and sweeps intrinsic settings.
// ----------------------------------------------------------------------------
module tb import ppfh_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint LIMIT_CYCLES = 2000000;
  localparam int     DRAIN_CYCLES = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  ppfh_stream_if #(.payload_t(in_item_t))  in_ch ();
  ppfh_stream_if #(.payload_t(out_item_t)) out_ch ();

  planar_pose_from_homography_unit dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #1 clk = ~clk;

  // Predictor copy of the intrinsic registers.
  logic [31:0] k_fx, k_fy, k_skew, k_cx, k_cy;

  in_item_t  homography_q[$];
  out_item_t pose_rows_q[$];
  int        errors = 0;
  longint    cycle_count = 0;
  bit        quiet_phase = 1'b0;
  bit        hold_long = 1'b0;
  bit        in_took = 1'b0;
  int        hold_cycles = 0;
  int        src_gap = 0;
  int        snk_gap = 0;

  // Append one item to the pending source queue.
  task automatic queue_item(input in_item_t h);
    homography_q.insert(homography_q.size(), h);
  endtask

  function automatic longint sat_q(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Floor shift of an exact product.
  function automatic longint shift_floor(input longint p);
    return p >>> 16;
  endfunction

  function automatic longint q_div(input longint n, input longint d);
    if (d == 0) return (n > 0) ? 64'sd2147483647 : (n < 0) ? -64'sd2147483648 : 0;
    return sat_q((n * 65536) / d);
  endfunction

  function automatic longint int_sqrt(input logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(res);
  endfunction

  // Back substitution through the intrinsic matrix for one column.
  function automatic void unproject(input longint a, input longint b, input longint c,
                                    output longint x0, output longint x1,
                                    output longint x2);
    longint fx, fy, cx, cy, s;
    fx = longint'({32'd0, k_fx});
    fy = longint'({32'd0, k_fy});
    cx = longint'({32'd0, k_cx});
    cy = longint'({32'd0, k_cy});
    s  = longint'(signed'(k_skew));
    x2 = c;
    x1 = q_div(sat_q(b - shift_floor(cy * c)), fy);
    x0 = q_div(sat_q(a - shift_floor(s * x1) - shift_floor(cx * c)), fx);
  endfunction

  // Expected pose rows for one homography.
  task automatic predict_pose(input in_item_t h);
    longint m0[3], m1[3], m2[3], r0[3], r1[3], r2[3], t[3];
    logic [63:0] sum, mag;
    longint norm;
    out_item_t row;
    unproject(h.h00, h.h10, h.h20, m0[0], m0[1], m0[2]);
    unproject(h.h01, h.h11, h.h21, m1[0], m1[1], m1[2]);
    unproject(h.h02, h.h12, h.h22, m2[0], m2[1], m2[2]);
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mag = (m0[i] < 0) ? -m0[i] : m0[i];
      sum += mag * mag;
      r0[i] = 0; r1[i] = 0; r2[i] = 0; t[i] = 0;
    end
    norm = int_sqrt(sum);
    if (norm != 0) begin
      for (int i = 0; i < 3; i++) begin
        r0[i] = q_div(m0[i], norm);
        r1[i] = q_div(m1[i], norm);
        t[i]  = q_div(m2[i], norm);
      end
      r2[0] = sat_q(shift_floor(r0[1] * r1[2] - r0[2] * r1[1]));
      r2[1] = sat_q(shift_floor(r0[2] * r1[0] - r0[0] * r1[2]));
      r2[2] = sat_q(shift_floor(r0[0] * r1[1] - r0[1] * r1[0]));
    end
    for (int i = 0; i < 3; i++) begin
      row.row_index   = 2'(i);
      row.rot_col0    = r0[i][31:0];
      row.rot_col1    = r1[i][31:0];
      row.rot_col2    = r2[i][31:0];
      row.translation = t[i][31:0];
      row.last_row    = (i == 2);
      row.degenerate  = (norm == 0);
      pose_rows_q.insert(pose_rows_q.size(), row);
    end
  endtask

  // Source side: offer queued items, with random idle bursts. The item at the
  // front of the queue is the one on the bus until a handshake takes it.
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_took) begin
      if (in_took) void'(homography_q.pop_front());
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (homography_q.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.data  <= homography_q[0];
        if (!quiet_phase && $urandom_range(0, 7) == 0) src_gap <= $urandom_range(1, 6);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Sink side: random idle bursts plus an optional long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_long) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles + 1;
    end else if (snk_gap > 0) begin
      snk_gap <= snk_gap - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (!quiet_phase && $urandom_range(0, 7) == 0) snk_gap <= $urandom_range(1, 6);
    end
  end

  // Prediction on each accepted input item; the handshake is also recorded
  // for the source side.
  always @(posedge clk) begin
    in_took <= !rst && in_ch.valid && in_ch.ready;
    if (!rst && in_ch.valid && in_ch.ready) predict_pose(in_ch.data);
  end

  // Check each accepted pose row against the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pose_rows_q.size() == 0) begin
        $display("%0t: unexpected row, actual %p", $realtime, out_ch.data);
        errors++;
      end else begin
        want = pose_rows_q.pop_front();
        if (out_ch.data !== want) begin
          $display("%0t: row mismatch, expected %p, actual %p", $realtime, want,
                   out_ch.data);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("planar_pose_from_homography_unit verification failed");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_FOCAL_X:  k_fx = val;
      REG_FOCAL_Y:  k_fy = val;
      REG_SKEW:     k_skew = val;
      REG_CENTER_X: k_cx = val;
      REG_CENTER_Y: k_cy = val;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (homography_q.size() > 0 || in_ch.valid || pose_rows_q.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_intrinsics(input logic [31:0] fx, input logic [31:0] fy,
                                input logic [31:0] s, input logic [31:0] cx,
                                input logic [31:0] cy);
    write_reg(REG_FOCAL_X, fx);
    write_reg(REG_FOCAL_Y, fy);
    write_reg(REG_SKEW, s);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
  endtask

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 200000)) - 100000);
      2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      3: return 32'($signed($urandom_range(0, 2000000000)) - 1000000000);
      default: return 32'($signed($urandom_range(0, 40000000)) - 20000000);
    endcase
  endfunction

  function automatic in_item_t rand_homography();
    in_item_t h;
    h = {rand_entry(), rand_entry(), rand_entry(), rand_entry(), rand_entry(),
         rand_entry(), rand_entry(), rand_entry(), rand_entry()};
    // A zero first column now and then to reach the degenerate path.
    if ($urandom_range(0, 19) == 0) begin
      h.h00 = 0; h.h10 = 0; h.h20 = 0;
    end
    return h;
  endfunction

  task automatic add_random(input int n);
    for (int i = 0; i < n; i++) queue_item(rand_homography());
  endtask

  initial begin
    in_item_t h;
    k_fx = FOCAL_RESET; k_fy = FOCAL_RESET; k_skew = 0; k_cx = 0; k_cy = 0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: identity, zero column, extremes, at reset intrinsics.
    h = '0; h.h00 = 32'sd65536; h.h11 = 32'sd65536; h.h22 = 32'sd65536;
    queue_item(h);
    h = '0; h.h01 = 32'sd65536; h.h22 = 32'sd3276800;
    queue_item(h);
    queue_item('0);
    queue_item({9{32'h7fff_ffff}});
    queue_item({9{32'h8000_0000}});
    queue_item({9{32'hffff_ffff}});
    h = '0; h.h20 = 32'sd1;
    queue_item(h);
    h = {32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
         32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
    queue_item(h);
    wait_idle();

    // Smallest focal lengths, extreme skew and center.
    set_intrinsics(32'd65536, 32'd65536, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    queue_item({9{32'h0001_0000}});
    queue_item({9{32'h8000_0000}});
    add_random(6);
    wait_idle();
    set_intrinsics(32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000, 32'd0, 32'd0);
    queue_item({9{32'h7fff_ffff}});
    add_random(6);
    wait_idle();

    // Random phases over varied intrinsics; one phase with a long sink hold.
    for (int p = 0; p < 5; p++) begin
      set_intrinsics($urandom_range(65536, 32'hffff_ffff), $urandom_range(65536, 90000000),
                     $urandom(), $urandom_range(0, 60000000), $urandom());
      add_random(70);
      if (p == 1) begin
        hold_long = 1'b1;
        while (hold_cycles < 600) @(posedge clk);
        @(negedge clk);
        hold_long = 1'b0;
      end
      wait_idle();
    end

    // Final stretch with no idling at reset-like intrinsics.
    set_intrinsics(FOCAL_RESET, FOCAL_RESET, 32'd0, 32'd20971520, 32'd15728640);
    quiet_phase = 1'b1;
    add_random(40);
    wait_idle();

    if (errors == 0) begin
      $display("planar_pose_from_homography_unit verification clean");
    end else begin
      $display("planar_pose_from_homography_unit verification failed");
    end
    $finish;
  end
endmodule
